// File: design/ffha_pkg.sv
// shared types and constants of the first-fit heap allocator
`timescale 1ns / 1ps

package ffha_pkg;

    localparam int AW = 22;                      // address and byte count width
    localparam logic [AW-1:0] ADDR_MAX = '1;

    localparam int DEF_MAX_BLOCKS   = 64;
    localparam int DEF_HEADER_BYTES = 8;
    localparam int DEF_GAP_BYTES    = 4;

    localparam logic [AW-1:0] HEAP_START_RST = 22'h101000;
    localparam logic [AW-1:0] HEAP_LIMIT_RST = 22'h3E0000;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic CFG_HEAP_START = 1'b0;
    localparam logic CFG_HEAP_LIMIT = 1'b1;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_NULL    = 3'd1;
    localparam logic [2:0] ST_OOM     = 3'd2;
    localparam logic [2:0] ST_FULL    = 3'd3;
    localparam logic [2:0] ST_UNKNOWN = 3'd4;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FIN
    } t_state;

    // search token moving down the row of cells
    typedef struct packed {
        logic          valid;
        logic          op;
        logic [AW-1:0] key;     // requested size or data address to free
        logic          hit;     // some cell already answered
        logic          ok;      // free found a taken block, also set on an alloc hit
        logic [AW-1:0] bytes;   // size of the block that answered
        logic [AW-1:0] start;   // header address of the block that answered
    } t_tok;

    // append write broadcast to the cells
    typedef struct packed {
        logic          en;
        logic [AW-1:0] start;
        logic [AW-1:0] bytes;
    } t_cell_wr;

endpackage

// File: design/first_fit_heap_allocator.sv
// top level of the first-fit heap allocator: request control, accounting, result register
`timescale 1ns / 1ps

// first-fit heap allocator over a table of MAX_BLOCKS blocks
//
// channels: the slave stream takes one request (tuser = opcode, alloc or free;
// tdata = size and free address), the master stream returns one result per
// request (data address, status, bytes in use). the config port writes
// heap_start (index 0, also empties the heap) or heap_limit (index 1); write
// only while no request is in flight.
//
// walk: a request walks the row of table cells one cell per cycle; a zero
// size alloc or a null free skips the walk. one request is handled at a
// time: a new request is accepted only after the last one has committed
// its result.
//
// reset empties the table (block count zero), puts the append pointer at the
// heap start, clears the byte total and restores the heap limit.
// when the receiver stalls, the result waits in the output register; a next
// request is still accepted and walked, and waits for that register to drain.
module first_fit_heap_allocator
    import ffha_pkg::*;
#(
    parameter int MAX_BLOCKS   = DEF_MAX_BLOCKS,
    parameter int HEADER_BYTES = DEF_HEADER_BYTES,
    parameter int GAP_BYTES    = DEF_GAP_BYTES
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // configuration write port
    input  logic          i_cfg_we,
    input  logic          i_cfg_idx,
    input  logic [AW-1:0] i_cfg_data,
    // request stream
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [47:0]   s_axis_tdata,   // req_size [21:0], free_addr [43:22], zero pad
    input  logic          s_axis_tuser,   // opcode [0]
    // result stream
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [47:0]   m_axis_tdata    // data_addr [21:0], status [24:22],
                                          // bytes_in_use [46:25], zero pad
);

    localparam int TW = $clog2(MAX_BLOCKS + 1);
    localparam int IW = $clog2(MAX_BLOCKS);

    // heap registers and running state
    logic [AW-1:0] r_heap_limit;
    logic [TW-1:0] r_total;
    logic [AW-1:0] r_next;
    logic [AW-1:0] r_used;

    // request held while it is walked
    t_state        r_state;
    t_state        n_state;
    logic          r_op;
    logic [AW-1:0] r_size;
    logic          r_skip;     // zero size or null address, no walk needed
    logic          r_hit;
    logic          r_ok;
    logic [AW-1:0] r_hbytes;
    logic [AW-1:0] r_hstart;

    // result register
    logic          r_out_valid;
    logic [AW-1:0] r_out_addr;
    logic [2:0]    r_out_status;
    logic [AW-1:0] r_out_used;

    logic          req_accept;
    logic          req_op;
    logic [AW-1:0] req_size;
    logic [AW-1:0] req_faddr;
    logic          req_skip;
    logic          commit;

    t_tok          tok_in;
    t_tok          tok_out;
    t_cell_wr      cell_wr;

    // finish stage arithmetic
    logic [AW+1:0] app_end;     // header address plus header plus size
    logic [AW+1:0] app_next;    // append pointer after the new block and gap
    logic [AW:0]   blk_amount;  // bytes plus header of the block that answered, or of the new block
    logic [AW+1:0] used_sum;
    logic [AW-1:0] res_addr;
    logic [2:0]    res_status;
    logic [AW-1:0] res_used;
    logic          res_append;

    assign req_op    = s_axis_tuser;
    assign req_size  = s_axis_tdata[AW-1:0];
    assign req_faddr = s_axis_tdata[2*AW-1:AW];
    assign req_skip  = (req_op == OP_ALLOC) ? (req_size == '0) : (req_faddr == '0);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = req_skip ? S_FIN : S_SCAN;
                end
            end
            S_SCAN: begin
                if (tok_out.valid) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control outputs of the state machine
    always_comb begin
        s_axis_tready = 1'b0;
        commit        = 1'b0;
        case (r_state)
            S_IDLE:  s_axis_tready = 1'b1;
            S_SCAN:  s_axis_tready = 1'b0;
            S_FIN:   commit = !r_out_valid || m_axis_tready;
            default: s_axis_tready = 1'b0;
        endcase
    end

    assign req_accept = s_axis_tvalid && s_axis_tready;

    // token enters the first cell on accept, unless the request skips the walk
    always_comb begin
        tok_in       = '0;
        tok_in.valid = req_accept && !req_skip;
        tok_in.op    = req_op;
        tok_in.key   = (req_op == OP_ALLOC) ? req_size : req_faddr;
    end

    // result of the request once the walk is done
    assign app_end    = {2'b00, r_next} + (AW+2)'(HEADER_BYTES) + {2'b00, r_size};
    assign app_next   = app_end + (AW+2)'(GAP_BYTES);
    assign blk_amount = (r_hit ? {1'b0, r_hbytes} : {1'b0, r_size}) + (AW+1)'(HEADER_BYTES);
    assign used_sum   = {2'b00, r_used} + {1'b0, blk_amount};

    always_comb begin
        res_addr   = '0;
        res_status = ST_OK;
        res_used   = r_used;
        res_append = 1'b0;
        if (r_skip) begin
            res_status = ST_NULL;
        end else if (r_op == OP_ALLOC) begin
            if (r_hit) begin
                // reuse a free block whole, no split
                res_addr = r_hstart + AW'(HEADER_BYTES);
                res_used = (used_sum > {2'b00, ADDR_MAX}) ? ADDR_MAX : used_sum[AW-1:0];
            end else if (app_end >= {2'b00, r_heap_limit}) begin
                res_status = ST_OOM;
            end else if (r_total >= TW'(MAX_BLOCKS)) begin
                res_status = ST_FULL;
            end else begin
                res_append = 1'b1;
                res_addr   = r_next + AW'(HEADER_BYTES);
                res_used   = (used_sum > {2'b00, ADDR_MAX}) ? ADDR_MAX : used_sum[AW-1:0];
            end
        end else begin
            if (r_hit && r_ok) begin
                res_used = ({1'b0, r_used} > blk_amount)
                           ? (r_used - blk_amount[AW-1:0]) : '0;
            end else begin
                // no block with that address, or it is already free
                res_status = ST_UNKNOWN;
            end
        end
    end

    // append goes into the first unused cell
    assign cell_wr.en    = commit && res_append;
    assign cell_wr.start = r_next;
    assign cell_wr.bytes = r_size;

    ffha_chain #(
        .MAX_BLOCKS   (MAX_BLOCKS),
        .HEADER_BYTES (HEADER_BYTES),
        .TW           (TW),
        .IW           (IW)
    ) u_chain (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_total  (r_total),
        .i_wr     (cell_wr),
        .i_wr_idx (r_total[IW-1:0]),
        .i_tok    (tok_in),
        .o_tok    (tok_out)
    );

    // state machine, heap state and config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_heap_limit <= HEAP_LIMIT_RST;
            r_total      <= '0;
            r_next       <= HEAP_START_RST;
            r_used       <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we && (i_cfg_idx == CFG_HEAP_START)) begin
                // new heap start empties the heap
                r_total      <= '0;
                r_next       <= i_cfg_data;
                r_used       <= '0;
            end else if (commit) begin
                r_used <= res_used;
                if (res_append) begin
                    r_total <= r_total + TW'(1);
                    r_next  <= (app_next > {2'b00, ADDR_MAX}) ? ADDR_MAX : app_next[AW-1:0];
                end
            end
            if (i_cfg_we && (i_cfg_idx == CFG_HEAP_LIMIT)) begin
                r_heap_limit <= i_cfg_data;
            end
        end
    end

    // request and walk result holding registers
    always_ff @(posedge i_clk) begin
        if (req_accept) begin
            r_op   <= req_op;
            r_size <= req_size;
            r_skip <= req_skip;
            r_hit  <= 1'b0;
        end else if ((r_state == S_SCAN) && tok_out.valid) begin
            r_hit    <= tok_out.hit;
            r_ok     <= tok_out.ok;
            r_hbytes <= tok_out.bytes;
            r_hstart <= tok_out.start;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (commit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (commit) begin
            r_out_addr   <= res_addr;
            r_out_status <= res_status;
            r_out_used   <= res_used;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out_used, r_out_status, r_out_addr};

    // the walk token only comes out while a request is being walked
    a_tok_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tok_out.valid |-> (r_state == S_SCAN))
        else $error("search token left the chain outside a walk");

    // block count never exceeds the table
    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= TW'(MAX_BLOCKS))
        else $error("block count beyond table size");

    // append pointer only moves up, except when the heap is restarted
    a_next_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$past(i_cfg_we)) |-> (r_next >= $past(r_next)))
        else $error("append pointer moved down");

    // a finished request always lands in the result register
    a_commit_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit |=> r_out_valid)
        else $error("result lost at commit");

    // byte total only changes by a commit or a heap restart
    a_used_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$past(commit) && !$past(i_cfg_we)) |-> $stable(r_used))
        else $error("byte total changed without a request");

endmodule

// File: design/ffha_cell.sv
// one table entry of the allocator with its stage of the search chain
`timescale 1ns / 1ps

module ffha_cell
    import ffha_pkg::*;
#(
    parameter int CELL_INDEX   = 0,
    parameter int TW           = 7,
    parameter int IW           = 6,
    parameter int HEADER_BYTES = DEF_HEADER_BYTES
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [TW-1:0] i_total,
    input  t_cell_wr      i_wr,
    input  logic [IW-1:0] i_wr_idx,
    input  t_tok          i_tok,
    output t_tok          o_tok
);

    logic [AW-1:0] r_start;
    logic [AW-1:0] r_bytes;
    logic          r_taken;
    t_tok          r_tok;
    t_tok          n_tok;

    logic          in_use;
    logic [AW-1:0] data_addr;
    logic          alloc_hit;
    logic          free_hit;

    assign in_use    = TW'(CELL_INDEX) < i_total;
    assign data_addr = r_start + AW'(HEADER_BYTES);
    assign alloc_hit = i_tok.valid && !i_tok.hit && (i_tok.op == OP_ALLOC) && in_use
                       && !r_taken && (r_bytes >= i_tok.key);
    assign free_hit  = i_tok.valid && !i_tok.hit && (i_tok.op == OP_FREE) && in_use
                       && (data_addr == i_tok.key);

    always_comb begin
        n_tok = i_tok;
        if (alloc_hit || free_hit) begin
            n_tok.hit   = 1'b1;
            n_tok.ok    = alloc_hit || r_taken;
            n_tok.bytes = r_bytes;
            n_tok.start = r_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else begin
            r_tok.valid <= n_tok.valid;
        end
        r_tok.op    <= n_tok.op;
        r_tok.key   <= n_tok.key;
        r_tok.hit   <= n_tok.hit;
        r_tok.ok    <= n_tok.ok;
        r_tok.bytes <= n_tok.bytes;
        r_tok.start <= n_tok.start;
    end

    // entry contents: appended by the controller, claimed or released by the token
    always_ff @(posedge i_clk) begin
        if (i_wr.en && (i_wr_idx == IW'(CELL_INDEX))) begin
            r_start <= i_wr.start;
            r_bytes <= i_wr.bytes;
            r_taken <= 1'b1;
        end else if (alloc_hit) begin
            r_taken <= 1'b1;
        end else if (free_hit) begin
            r_taken <= 1'b0;
        end
    end

    assign o_tok = r_tok;

endmodule

// File: design/ffha_chain.sv
// row of allocator cells, the search token moves one cell per cycle
`timescale 1ns / 1ps

module ffha_chain
    import ffha_pkg::*;
#(
    parameter int MAX_BLOCKS   = DEF_MAX_BLOCKS,
    parameter int HEADER_BYTES = DEF_HEADER_BYTES,
    parameter int TW           = $clog2(MAX_BLOCKS + 1),
    parameter int IW           = $clog2(MAX_BLOCKS)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [TW-1:0] i_total,
    input  t_cell_wr      i_wr,
    input  logic [IW-1:0] i_wr_idx,
    input  t_tok          i_tok,
    output t_tok          o_tok
);

    t_tok link [MAX_BLOCKS+1];

    assign link[0] = i_tok;

    for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
        ffha_cell #(
            .CELL_INDEX   (g),
            .TW           (TW),
            .IW           (IW),
            .HEADER_BYTES (HEADER_BYTES)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_total  (i_total),
            .i_wr     (i_wr),
            .i_wr_idx (i_wr_idx),
            .i_tok    (link[g]),
            .o_tok    (link[g+1])
        );
    end

    assign o_tok = link[MAX_BLOCKS];

endmodule
